@@ rtl/rfdt_pkg.sv @@
// ----------------------------------------------------------------------------
// rfdt_pkg: shared types and constants for the ring fault diagnosis tester
// Process ids, view table codes, item kinds, sequencer states and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rfdt_pkg;

  // Ring geometry
  localparam int MaxProcs   = 16;
  localparam int ProcW      = 4;
  localparam int CountW     = 5;
  localparam int ViewAddrW  = 2 * ProcW;
  localparam int ViewDepth  = MaxProcs * MaxProcs;
  localparam int ViewW      = 2;

  localparam logic [CountW-1:0] ProcCountReset = CountW'(5);
  localparam logic [CountW-1:0] RingMin        = CountW'(2);
  localparam logic [CountW-1:0] RingMax        = CountW'(MaxProcs);
  localparam logic [ViewAddrW-1:0] ViewAddrLast = ViewAddrW'(ViewDepth - 1);

  // Item kinds
  localparam logic [1:0] KIND_TEST    = 2'd0;
  localparam logic [1:0] KIND_FAIL    = 2'd1;
  localparam logic [1:0] KIND_RECOVER = 2'd2;

  // View table entry codes
  typedef enum logic [ViewW-1:0] {
    VIEW_UNKNOWN = 2'd0,
    VIEW_CORRECT = 2'd1,
    VIEW_SUSPECT = 2'd2
  } view_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_COPY,
    ST_DONE
  } state_t;

  // Clamp the configured ring size to the supported range
  function automatic logic [CountW-1:0] ring_size(input logic [CountW-1:0] cnt);
    logic [CountW-1:0] n;
    n = cnt;
    if (n < RingMin) n = RingMin;
    if (n > RingMax) n = RingMax;
    return n;
  endfunction

  // Next process around the ring
  function automatic logic [ProcW-1:0] ring_inc(input logic [ProcW-1:0] p,
                                                input logic [CountW-1:0] n);
    logic [CountW-1:0] s;
    s = {1'b0, p} + CountW'(1);
    return (s == n) ? '0 : s[ProcW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/rfdt_ram.sv @@
// ----------------------------------------------------------------------------
// rfdt_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rfdt_ram #(
  parameter int Width = 2,
  parameter int Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/ring_fault_diagnosis_tester_top.sv @@
// ----------------------------------------------------------------------------
// ring_fault_diagnosis_tester_top: adaptive ring diagnosis sequencer
// Keeps a fault mask and a per-process view table; runs test rounds.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, kind, proc_id) takes one word per item:
//   a test round by proc_id, a failure of proc_id or a recovery of proc_id.
//   Output channel (out_valid/out_ready) returns exactly one word per item.
//   cfg_we/cfg_wdata set the ring size; write it only while the block idles.
//   Order: fail, recover, ignored items and tests by a faulty process go
//   from the idle state straight to the final state, which loads the
//   output register once it is free. A test by a correct process first
//   visits its successors in the walk (up to the ring size), then copies
//   the view entries of the successor found, writing each entry after its
//   registered read from the view RAM, then loads the output register.
//   One item is in flight at a time: in_ready is high only while the
//   sequencer is idle.
//   After reset a clearing pass sweeps the 256-entry view RAM, one entry
//   per cycle, with in_ready low until the pass ends; the ring size
//   register is accepted during that time.
//   When the receiver stalls, the result word holds in the output register
//   and the sequencer waits in its final state, so no input is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_fault_diagnosis_tester_top (
  input  wire logic       clk,
  input  wire logic       rst,
  // input channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] kind,
  input  wire logic [3:0] proc_id,
  // output channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            tester_faulty,
  output logic            found_correct,
  output logic [3:0]      correct_successor,
  output logic [3:0]      suspects_seen,
  // configuration
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_wdata
);

  // Control state
  rfdt_pkg::state_t state, state_next;
  logic [rfdt_pkg::ViewAddrW-1:0] clr_addr, clr_addr_next;
  logic [rfdt_pkg::MaxProcs-1:0]  fault_mask, fault_mask_next;
  logic [rfdt_pkg::CountW-1:0]    proc_count;
  logic                           rd_pend, rd_pend_next;

  // Working registers
  logic [rfdt_pkg::ProcW-1:0] tester, tester_next;
  logic [rfdt_pkg::ProcW-1:0] succ, succ_next;
  logic [rfdt_pkg::ProcW-1:0] copy_col, copy_col_next;
  logic [rfdt_pkg::ProcW-1:0] wr_col, wr_col_next;
  logic [rfdt_pkg::ProcW-1:0] suspects, suspects_next;
  logic                       res_faulty, res_faulty_next;
  logic                       res_found, res_found_next;
  logic [rfdt_pkg::ProcW-1:0] res_succ, res_succ_next;
  logic [rfdt_pkg::ProcW-1:0] res_susp, res_susp_next;

  logic load_out;
  logic [rfdt_pkg::CountW-1:0] ring_n;

  // View RAM ports
  logic                           ram_we;
  logic [rfdt_pkg::ViewAddrW-1:0] ram_waddr;
  logic [rfdt_pkg::ViewW-1:0]     ram_wdata;
  logic [rfdt_pkg::ViewAddrW-1:0] ram_raddr;
  logic [rfdt_pkg::ViewW-1:0]     ram_rdata;

  assign ring_n = rfdt_pkg::ring_size(proc_count);

  // View table: row is the viewing process, column the viewed one.
  // Walk and copy write row tester, copy reads row succ (never the same
  // row), so reads and writes never touch the same entry.
  rfdt_ram #(
    .Width(rfdt_pkg::ViewW),
    .Depth(rfdt_pkg::ViewDepth)
  ) u_view_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rfdt_pkg::ST_CLEAR;
      clr_addr   <= '0;
      fault_mask <= '0;
      rd_pend    <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      fault_mask <= fault_mask_next;
      rd_pend    <= rd_pend_next;
    end
  end

  // Ring size register
  always_ff @(posedge clk) begin
    if (rst) begin
      proc_count <= rfdt_pkg::ProcCountReset;
    end else if (cfg_we) begin
      proc_count <= cfg_wdata;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    tester     <= tester_next;
    succ       <= succ_next;
    copy_col   <= copy_col_next;
    wr_col     <= wr_col_next;
    suspects   <= suspects_next;
    res_faulty <= res_faulty_next;
    res_found  <= res_found_next;
    res_succ   <= res_succ_next;
    res_susp   <= res_susp_next;
  end

  // Sequencer: next state, RAM access and working register updates
  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    fault_mask_next = fault_mask;
    rd_pend_next    = rd_pend;
    tester_next     = tester;
    succ_next       = succ;
    copy_col_next   = copy_col;
    wr_col_next     = wr_col;
    suspects_next   = suspects;
    res_faulty_next = res_faulty;
    res_found_next  = res_found;
    res_succ_next   = res_succ;
    res_susp_next   = res_susp;
    ram_we          = 1'b0;
    ram_waddr       = {tester, succ};
    ram_wdata       = rfdt_pkg::VIEW_UNKNOWN;
    ram_raddr       = {succ, copy_col};
    in_ready        = 1'b0;
    load_out        = 1'b0;

    unique case (state)
      // Sweep the view RAM: own entry correct, all others unknown
      rfdt_pkg::ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = (clr_addr[rfdt_pkg::ViewAddrW-1:rfdt_pkg::ProcW] ==
                         clr_addr[rfdt_pkg::ProcW-1:0]) ?
                        rfdt_pkg::VIEW_CORRECT : rfdt_pkg::VIEW_UNKNOWN;
        clr_addr_next = clr_addr + rfdt_pkg::ViewAddrW'(1);
        if (clr_addr == rfdt_pkg::ViewAddrLast) begin
          state_next = rfdt_pkg::ST_IDLE;
        end
      end

      // Take one word and decode it
      rfdt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          tester_next     = proc_id;
          succ_next       = rfdt_pkg::ring_inc(proc_id, ring_n);
          suspects_next   = '0;
          res_faulty_next = 1'b0;
          res_found_next  = 1'b0;
          res_succ_next   = '0;
          res_susp_next   = '0;
          state_next      = rfdt_pkg::ST_DONE;
          if ({1'b0, proc_id} < ring_n) begin
            case (kind)
              rfdt_pkg::KIND_FAIL: begin
                fault_mask_next = fault_mask | (rfdt_pkg::MaxProcs'(1) << proc_id);
              end
              rfdt_pkg::KIND_RECOVER: begin
                fault_mask_next = fault_mask & ~(rfdt_pkg::MaxProcs'(1) << proc_id);
              end
              rfdt_pkg::KIND_TEST: begin
                if (fault_mask[proc_id]) begin
                  res_faulty_next = 1'b1;
                end else begin
                  state_next = rfdt_pkg::ST_WALK;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      // Visit one successor per cycle until a correct one turns up
      rfdt_pkg::ST_WALK: begin
        ram_we    = 1'b1;
        ram_waddr = {tester, succ};
        if (fault_mask[succ]) begin
          ram_wdata     = rfdt_pkg::VIEW_SUSPECT;
          suspects_next = suspects + rfdt_pkg::ProcW'(1);
          succ_next     = rfdt_pkg::ring_inc(succ, ring_n);
        end else begin
          ram_wdata     = rfdt_pkg::VIEW_CORRECT;
          res_susp_next = suspects;
          if (succ == tester) begin
            state_next = rfdt_pkg::ST_DONE;
          end else begin
            res_found_next = 1'b1;
            res_succ_next  = succ;
            copy_col_next  = rfdt_pkg::ring_inc(succ, ring_n);
            rd_pend_next   = 1'b0;
            state_next     = rfdt_pkg::ST_COPY;
          end
        end
      end

      // Read row succ, write each entry into row tester in the following cycle
      rfdt_pkg::ST_COPY: begin
        ram_we    = rd_pend;
        ram_waddr = {tester, wr_col};
        ram_wdata = ram_rdata;
        ram_raddr = {succ, copy_col};
        if (copy_col != tester) begin
          rd_pend_next  = 1'b1;
          wr_col_next   = copy_col;
          copy_col_next = rfdt_pkg::ring_inc(copy_col, ring_n);
        end else begin
          rd_pend_next = 1'b0;
          if (!rd_pend) begin
            state_next = rfdt_pkg::ST_DONE;
          end
        end
      end

      // Hand the result to the output register once it is free
      rfdt_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = rfdt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = rfdt_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      tester_faulty     <= res_faulty;
      found_correct     <= res_found;
      correct_successor <= res_succ;
      suspects_seen     <= res_susp;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rfdt_checker.sv @@
// ----------------------------------------------------------------------------
// rfdt_checker: port-level checks for the ring fault diagnosis tester
// Watches the top level's ports; attached by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module rfdt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       tester_faulty,
  input wire logic       found_correct,
  input wire logic [3:0] correct_successor,
  input wire logic [3:0] suspects_seen
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tester_faulty) &&
      $stable(found_correct) && $stable(correct_successor) && $stable(suspects_seen))
    else $error("stalled result word changed");

  // Drop a test by a faulty process without any walk result
  a_faulty_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && tester_faulty |-> !found_correct && suspects_seen == 4'd0 &&
      correct_successor == 4'd0)
    else $error("ignored test carries walk results");

  // Take one word at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  // Hold off input while the view table is cleared after reset
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("ready or valid right after reset");

endmodule

bind ring_fault_diagnosis_tester_top rfdt_checker u_rfdt_checker (.*);

`default_nettype wire
